### rtl/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared constants and types for the image header CRC-24 verifier.
// ----------------------------------------------------------------------------
package ihc_pkg;

    // Header layout and checks
    localparam logic [23:0] IMG_MAGIC      = 24'hFEDBAD;
    localparam logic [23:0] MAX_LEN_RESET  = 24'd131072;
    localparam logic [3:0]  HDR_LAST_BYTE  = 4'd8;

    // CRC-24 generator, x^24 term implied
    localparam logic [23:0] CRC_POLY       = 24'h864CFB;

    // Payload widths
    localparam int unsigned STATUS_W       = 2;
    localparam int unsigned WORD_W         = 24;
    localparam int unsigned OUT_TDATA_W    = 56;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MAGIC = 2'd1,
        ST_TOO_BIG   = 2'd2,
        ST_CRC_BAD   = 2'd3
    } status_t;

    // Image parsing phase
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

endpackage

### rtl/ihc_crc24_step.sv
// ----------------------------------------------------------------------------
// ihc_crc24_step
// One-byte CRC-24 update, MSB first, no reflection.
// ----------------------------------------------------------------------------
module ihc_crc24_step
(
    input  logic [23:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [23:0] crc_out
);
    import ihc_pkg::*;

    logic [23:0] crc_work;

    // Eight shift/xor steps over the byte
    always_comb
    begin
        crc_work = crc_in ^ {data_in, 16'h0000};
        for (int k = 0; k < 8; k++)
        begin
            if (crc_work[23])
            begin
                crc_work = {crc_work[22:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc_work = {crc_work[22:0], 1'b0};
            end
        end
        crc_out = crc_work;
    end

endmodule

### rtl/image_header_crc24_verifier_core.sv
// ----------------------------------------------------------------------------
// image_header_crc24_verifier_core
// Checks a stored program image header and its CRC-24 over the data bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Image bytes enter on the s_axis channel, one byte per request; tuser
//   marks the first header byte of a new image and restarts parsing at any
//   time. The 9-byte header holds magic, CRC and length, each 24 bits
//   little-endian. One status result leaves on m_axis: after the last data
//   byte, or right after the header when magic or length are bad or the
//   length is zero. Bytes after a result are dropped until the next start.
//   max_image_length is loaded through cfg_wr_en / cfg_wr_data while idle.
// Timing:
//   A byte is captured in an input register, processed once the output
//   register is free or being read, and its result lands in the output
//   register. One byte per cycle is sustained while no result is held up
//   on m_axis; the byte-wide CRC update sits between the two registers.
// Reset and stall:
//   Reset clears all parsing state and sets max_image_length to 131072.
//   While m_axis_tready is low with a result pending, the input register
//   holds one more byte and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module image_header_crc24_verifier_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [ihc_pkg::WORD_W-1:0]     cfg_wr_data,    // max_image_length
    // byte stream in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    input  logic                           s_axis_tuser,   // [0] start_req
    // status out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] status, [25:2] image_length, [49:26] computed_crc, [55:50] zero
    output logic [ihc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ihc_pkg::*;

    // Configuration register
    logic [WORD_W-1:0] max_len_reg;

    // Input register
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_start_reg;

    // Parsing state
    phase_t            phase_reg,  phase_next;
    logic [3:0]        hcnt_reg,   hcnt_next;
    logic [WORD_W-1:0] magic_reg,  magic_next;
    logic [WORD_W-1:0] hcrc_reg,   hcrc_next;
    logic [WORD_W-1:0] len_reg,    len_next;
    logic [WORD_W-1:0] rem_reg,    rem_next;
    logic [WORD_W-1:0] rcrc_reg,   rcrc_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // Working signals
    logic              proceed;
    logic              emit;
    status_t           emit_status;
    logic [WORD_W-1:0] crc_upd;
    phase_t            eff_phase;
    logic [3:0]        eff_hcnt;
    logic [WORD_W-1:0] eff_magic;
    logic [WORD_W-1:0] eff_hcrc;
    logic [WORD_W-1:0] eff_len;
    logic [WORD_W-1:0] eff_rcrc;

    // Handshake
    assign proceed       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proceed;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Byte-wide CRC update
    ihc_crc24_step u_crc
    (
        .crc_in  (rcrc_reg),
        .data_in (in_byte_reg),
        .crc_out (crc_upd)
    );

    // A start byte drops the image in progress
    assign eff_phase = in_start_reg ? PH_HEADER : phase_reg;
    assign eff_hcnt  = in_start_reg ? 4'd0 : hcnt_reg;
    assign eff_magic = in_start_reg ? '0 : magic_reg;
    assign eff_hcrc  = in_start_reg ? '0 : hcrc_reg;
    assign eff_len   = in_start_reg ? '0 : len_reg;
    assign eff_rcrc  = in_start_reg ? '0 : rcrc_reg;

    // Per-byte parsing step
    always_comb
    begin
        phase_next  = phase_reg;
        hcnt_next   = hcnt_reg;
        magic_next  = magic_reg;
        hcrc_next   = hcrc_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        rcrc_next   = rcrc_reg;
        emit        = 1'b0;
        emit_status = ST_OK;
        if (proceed)
        begin
            phase_next = eff_phase;
            hcnt_next  = eff_hcnt;
            magic_next = eff_magic;
            hcrc_next  = eff_hcrc;
            len_next   = eff_len;
            rem_next   = in_start_reg ? '0 : rem_reg;
            rcrc_next  = eff_rcrc;
            unique case (eff_phase)
                PH_HEADER:
                begin
                    // store the byte in its header word
                    unique case (eff_hcnt)
                        4'd0:    magic_next[7:0]   = in_byte_reg;
                        4'd1:    magic_next[15:8]  = in_byte_reg;
                        4'd2:    magic_next[23:16] = in_byte_reg;
                        4'd3:    hcrc_next[7:0]    = in_byte_reg;
                        4'd4:    hcrc_next[15:8]   = in_byte_reg;
                        4'd5:    hcrc_next[23:16]  = in_byte_reg;
                        4'd6:    len_next[7:0]     = in_byte_reg;
                        4'd7:    len_next[15:8]    = in_byte_reg;
                        4'd8:    len_next[23:16]   = in_byte_reg;
                        default: ;
                    endcase
                    hcnt_next = eff_hcnt + 4'd1;
                    // header complete: magic, then length, then empty image
                    if (eff_hcnt == HDR_LAST_BYTE)
                    begin
                        priority if (magic_next != IMG_MAGIC)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_BAD_MAGIC;
                        end
                        else if (len_next > max_len_reg)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_TOO_BIG;
                        end
                        else if (len_next == '0)
                        begin
                            emit        = 1'b1;
                            emit_status = (eff_rcrc == hcrc_next) ? ST_OK : ST_CRC_BAD;
                        end
                        else
                        begin
                            rem_next   = len_next;
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    rcrc_next = crc_upd;
                    rem_next  = rem_reg - 24'd1;
                    if (rem_next == '0)
                    begin
                        emit        = 1'b1;
                        emit_status = (crc_upd == hcrc_reg) ? ST_OK : ST_CRC_BAD;
                    end
                end
                PH_IDLE, PH_DONE: ;
                default: ;
            endcase
            if (emit)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            hcnt_reg      <= '0;
            magic_reg     <= '0;
            hcrc_reg      <= '0;
            len_reg       <= '0;
            rem_reg       <= '0;
            rcrc_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            hcnt_reg      <= hcnt_next;
            magic_reg     <= magic_next;
            hcrc_reg      <= hcrc_next;
            len_reg       <= len_next;
            rem_reg       <= rem_next;
            rcrc_reg      <= rcrc_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
        if (emit)
        begin
            out_data_reg <= {6'b000000, rcrc_next, len_next, emit_status};
        end
    end

    // Checks
    a_hdr_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (hcnt_reg <= HDR_LAST_BYTE))
        else $error("header byte count out of range");

    a_data_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (rem_reg != '0 && rem_reg <= len_reg))
        else $error("remaining byte count inconsistent with length");

    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg && phase_reg == PH_DONE))
        else $error("result not registered after emit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !emit)
        else $error("pending result overwritten");

endmodule
